>>> hdl/dpgc_pkg.sv
// Package for the disparity plane ground classifier: constants, register codes and types.
package dpgc_pkg;

   localparam int IMG_WIDTH  = 1024;
   localparam int IMG_HEIGHT = 1024;

   // Signed width of 2*coord - size, covers image sizes up to 8192
   localparam int DX_W = 15;

   localparam int M_W   = 84;   // numerator * disparity * 2^48
   localparam int LMB_W = 28;   // limb width for the squaring
   localparam int SQ_W  = 2 * M_W;
   localparam int L2_W  = 78;   // (limit * disparity)^2
   localparam int RL_W  = 26;   // limb width for the rhs product
   localparam int R_W   = L2_W + 32;
   localparam int RSH   = 34;   // rhs scale 2^34

   localparam logic [2:0] REG_PLANE_A   = 3'd0;
   localparam logic [2:0] REG_PLANE_B   = 3'd1;
   localparam logic [2:0] REG_PLANE_C   = 3'd2;
   localparam logic [2:0] REG_OFFSET    = 3'd3;
   localparam logic [2:0] REG_LIMIT     = 3'd4;
   localparam logic [2:0] REG_BASELINE  = 3'd5;
   localparam logic [2:0] REG_FOCAL     = 3'd6;

   localparam logic [7:0] PIX_GROUND = 8'd255;

   typedef struct packed {
      logic signed [15:0] plane_a;
      logic signed [15:0] plane_b;
      logic signed [15:0] plane_c;
      logic signed [31:0] plane_offset;
      logic [30:0]        distance_limit;
      logic [31:0]        baseline_len;
      logic [31:0]        focal_len;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       disp_nz;
   } side_type;

endpackage

>>> hdl/dpgc_front.sv
// Front pipeline, stages 1 to 3: plane numerator and squared limit term.
module dpgc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [9:0]                    column,
   input  logic [9:0]                    row,
   input  logic [7:0]                    disparity,
   input  logic [7:0]                    pixel_in,
   input  dpgc_pkg::cfg_type             cfg,
   output logic                          out_valid,
   output logic signed [dpgc_pkg::M_W-1:0] out_m,
   output logic [dpgc_pkg::L2_W-1:0]     out_l2,
   output logic [31:0]                   out_nq,
   output dpgc_pkg::side_type            out_side
);

   // stage 1
   logic v1_ff, v1_in;
   logic signed [dpgc_pkg::DX_W+15:0] pax_ff, pax_in, pby_ff, pby_in;
   logic signed [48:0] pcf_ff, pcf_in;
   logic signed [40:0] pod_ff, pod_in;
   logic [38:0]        pld_ff, pld_in;
   logic [31:0]        nq1_ff, nq1_in;
   dpgc_pkg::side_type side1_ff, side1_in;

   // stage 2
   logic v2_ff, v2_in;
   logic signed [48:0] sbl_ff, sbl_in, sbh_ff, sbh_in;
   logic [55:0]        cfbl_ff, cfbl_in;
   logic signed [57:0] cfbh_ff, cfbh_in;
   logic signed [40:0] pod2_ff, pod2_in;
   logic [39:0]        ll_ff, ll_in;
   logic [38:0]        lh_ff, lh_in;
   logic [37:0]        hh_ff, hh_in;
   logic [31:0]        nq2_ff, nq2_in;
   dpgc_pkg::side_type side2_ff, side2_in;

   // stage 3
   logic v3_ff, v3_in;
   logic signed [dpgc_pkg::M_W-1:0] m_ff, m_in;
   logic [dpgc_pkg::L2_W-1:0] l2_ff, l2_in;
   logic [31:0]        nq3_ff, nq3_in;
   dpgc_pkg::side_type side3_ff, side3_in;

   always_comb begin
      logic signed [dpgc_pkg::DX_W-1:0] dx, dy;
      logic signed [32:0] sq_a, sq_b, sq_c;
      dx = $signed(dpgc_pkg::DX_W'({column, 1'b0}))
           - $signed(dpgc_pkg::DX_W'(dpgc_pkg::IMG_WIDTH));
      dy = $signed(dpgc_pkg::DX_W'({row, 1'b0}))
           - $signed(dpgc_pkg::DX_W'(dpgc_pkg::IMG_HEIGHT));
      v1_in  = in_valid;
      pax_in = cfg.plane_a * dx;
      pby_in = cfg.plane_b * dy;
      pcf_in = cfg.plane_c * $signed({1'b0, cfg.focal_len});
      pod_in = cfg.plane_offset * $signed({1'b0, disparity});
      pld_in = 39'(cfg.distance_limit) * 39'(disparity);
      sq_a   = cfg.plane_a * cfg.plane_a;
      sq_b   = cfg.plane_b * cfg.plane_b;
      sq_c   = cfg.plane_c * cfg.plane_c;
      nq1_in = 32'(sq_a + sq_b + sq_c);
      side1_in.pixel   = pixel_in;
      side1_in.disp_nz = (disparity != 8'd0);
   end

   always_comb begin
      logic signed [31:0] s;
      logic signed [16:0] bl, bh;
      logic signed [32:0] bs;
      logic signed [24:0] cfh;
      s    = 32'(pax_ff) + 32'(pby_ff);
      bl   = $signed({1'b0, cfg.baseline_len[15:0]});
      bh   = $signed({1'b0, cfg.baseline_len[31:16]});
      bs   = $signed({1'b0, cfg.baseline_len});
      cfh  = pcf_ff[48:24];
      v2_in   = v1_ff;
      sbl_in  = s * bl;
      sbh_in  = s * bh;
      cfbl_in = 56'(pcf_ff[23:0]) * 56'(cfg.baseline_len);
      cfbh_in = cfh * bs;
      pod2_in = pod_ff;
      ll_in   = 40'(pld_ff[19:0]) * 40'(pld_ff[19:0]);
      lh_in   = 39'(pld_ff[19:0]) * 39'(pld_ff[38:20]);
      hh_in   = 38'(pld_ff[38:20]) * 38'(pld_ff[38:20]);
      nq2_in  = nq1_ff;
      side2_in = side1_ff;
   end

   always_comb begin
      logic signed [dpgc_pkg::M_W-1:0] sb, cfb;
      sb  = dpgc_pkg::M_W'(sbl_ff) + (dpgc_pkg::M_W'(sbh_ff) <<< 16);
      cfb = $signed(dpgc_pkg::M_W'({1'b0, cfbl_ff})) + (dpgc_pkg::M_W'(cfbh_ff) <<< 24);
      v3_in = v2_ff;
      m_in  = (sb <<< 16) + (cfb <<< 1) + (dpgc_pkg::M_W'(pod2_ff) <<< 32);
      l2_in = dpgc_pkg::L2_W'(ll_ff) + (dpgc_pkg::L2_W'(lh_ff) << 21)
              + (dpgc_pkg::L2_W'(hh_ff) << 40);
      nq3_in   = nq2_ff;
      side3_in = side2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pax_ff <= pax_in;  pby_ff <= pby_in;  pcf_ff <= pcf_in;
         pod_ff <= pod_in;  pld_ff <= pld_in;  nq1_ff <= nq1_in;
         side1_ff <= side1_in;
         sbl_ff <= sbl_in;  sbh_ff <= sbh_in;
         cfbl_ff <= cfbl_in; cfbh_ff <= cfbh_in;
         pod2_ff <= pod2_in;
         ll_ff <= ll_in;  lh_ff <= lh_in;  hh_ff <= hh_in;
         nq2_ff <= nq2_in;  side2_ff <= side2_in;
         m_ff <= m_in;  l2_ff <= l2_in;  nq3_ff <= nq3_in;
         side3_ff <= side3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_m     = m_ff;
   assign out_l2    = l2_ff;
   assign out_nq    = nq3_ff;
   assign out_side  = side3_ff;

endmodule

>>> hdl/dpgc_square.sv
// Back pipeline, stages 4 to 6: numerator square and scaled limit product.
module dpgc_square (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [dpgc_pkg::M_W-1:0] in_m,
   input  logic [dpgc_pkg::L2_W-1:0]       in_l2,
   input  logic [31:0]                     in_nq,
   input  dpgc_pkg::side_type              in_side,
   output logic                            out_valid,
   output logic [dpgc_pkg::SQ_W-1:0]       out_sq,
   output logic [dpgc_pkg::R_W-1:0]        out_r,
   output dpgc_pkg::side_type              out_side
);

   localparam int PW = 2 * dpgc_pkg::LMB_W;
   localparam int RP = dpgc_pkg::RL_W + 32;

   logic v4_ff, v4_in, v5_ff, v5_in, v6_ff, v6_in;
   logic [dpgc_pkg::M_W-1:0] mag_ff, mag_in;
   logic [RP-1:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in;
   dpgc_pkg::side_type side4_ff, side4_in, side5_ff, side5_in, side6_ff, side6_in;
   logic [PW-1:0] p00_ff, p00_in, p01_ff, p01_in, p02_ff, p02_in;
   logic [PW-1:0] p11_ff, p11_in, p12_ff, p12_in, p22_ff, p22_in;
   logic [dpgc_pkg::R_W-1:0] r5_ff, r5_in, r6_ff, r6_in;
   logic [dpgc_pkg::SQ_W-1:0] sq_ff, sq_in;

   always_comb begin
      v4_in  = in_valid;
      mag_in = in_m[dpgc_pkg::M_W-1] ? dpgc_pkg::M_W'(-in_m) : dpgc_pkg::M_W'(in_m);
      r0_in  = RP'(in_l2[dpgc_pkg::RL_W-1:0]) * RP'(in_nq);
      r1_in  = RP'(in_l2[2*dpgc_pkg::RL_W-1:dpgc_pkg::RL_W]) * RP'(in_nq);
      r2_in  = RP'(in_l2[3*dpgc_pkg::RL_W-1:2*dpgc_pkg::RL_W]) * RP'(in_nq);
      side4_in = in_side;
   end

   always_comb begin
      logic [dpgc_pkg::LMB_W-1:0] m0, m1, m2;
      m0 = mag_ff[dpgc_pkg::LMB_W-1:0];
      m1 = mag_ff[2*dpgc_pkg::LMB_W-1:dpgc_pkg::LMB_W];
      m2 = mag_ff[3*dpgc_pkg::LMB_W-1:2*dpgc_pkg::LMB_W];
      v5_in  = v4_ff;
      p00_in = PW'(m0) * PW'(m0);
      p01_in = PW'(m0) * PW'(m1);
      p02_in = PW'(m0) * PW'(m2);
      p11_in = PW'(m1) * PW'(m1);
      p12_in = PW'(m1) * PW'(m2);
      p22_in = PW'(m2) * PW'(m2);
      r5_in  = dpgc_pkg::R_W'(r0_ff) + (dpgc_pkg::R_W'(r1_ff) << dpgc_pkg::RL_W)
               + (dpgc_pkg::R_W'(r2_ff) << (2 * dpgc_pkg::RL_W));
      side5_in = side4_ff;
   end

   always_comb begin
      v6_in = v5_ff;
      sq_in = dpgc_pkg::SQ_W'(p00_ff)
            + (dpgc_pkg::SQ_W'(p01_ff) << (dpgc_pkg::LMB_W + 1))
            + ((dpgc_pkg::SQ_W'(p02_ff) << 1) + dpgc_pkg::SQ_W'(p11_ff)
               << (2 * dpgc_pkg::LMB_W))
            + (dpgc_pkg::SQ_W'(p12_ff) << (3 * dpgc_pkg::LMB_W + 1))
            + (dpgc_pkg::SQ_W'(p22_ff) << (4 * dpgc_pkg::LMB_W));
      r6_in = r5_ff;
      side6_in = side5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;  r0_ff <= r0_in;  r1_ff <= r1_in;  r2_ff <= r2_in;
         side4_ff <= side4_in;
         p00_ff <= p00_in;  p01_ff <= p01_in;  p02_ff <= p02_in;
         p11_ff <= p11_in;  p12_ff <= p12_in;  p22_ff <= p22_in;
         r5_ff <= r5_in;  side5_ff <= side5_in;
         sq_ff <= sq_in;  r6_ff <= r6_in;  side6_ff <= side6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_sq    = sq_ff;
   assign out_r     = r6_ff;
   assign out_side  = side6_ff;

endmodule

>>> hdl/disparity_plane_ground_classifier.sv
// Top level of the disparity plane ground classifier: registers, pipeline and output stage.
// Seven-stage pipeline, one pixel per clock while rsp_ready stays high: a pixel transfer
// on req_ comes out as a rsp_ transfer after passing every stage. The test is exact,
// (numerator*d)^2 against limit^2*d^2*|n|^2, done in wide fixed point with every
// multiplier cut to 32x32 or less: stages 1-3 build the plane numerator and the
// limit term, 4-6 square it in 28-bit limbs, 7 compares and holds the result.
// The whole pipeline stalls together while the output register is full and not
// taken, so req_ready follows rsp_ready combinationally. Zero disparity, a zero
// normal or a zero limit never mark ground. Configuration writes are always
// taken (csr_ready is high); indexes past the register list are dropped.
module disparity_plane_ground_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_column,
   input  logic [9:0]  req_row,
   input  logic [7:0]  req_disparity,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_is_ground,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   dpgc_pkg::cfg_type cfg_ff, cfg_in;

   logic en;
   logic f_valid, s_valid;
   logic signed [dpgc_pkg::M_W-1:0] f_m;
   logic [dpgc_pkg::L2_W-1:0] f_l2;
   logic [31:0] f_nq;
   dpgc_pkg::side_type f_side, s_side;
   logic [dpgc_pkg::SQ_W-1:0] s_sq;
   logic [dpgc_pkg::R_W-1:0]  s_r;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] pix_ff, pix_in;
   logic       gnd_ff, gnd_in;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dpgc_pkg::REG_PLANE_A:  cfg_in.plane_a        = $signed(csr_data[15:0]);
            dpgc_pkg::REG_PLANE_B:  cfg_in.plane_b        = $signed(csr_data[15:0]);
            dpgc_pkg::REG_PLANE_C:  cfg_in.plane_c        = $signed(csr_data[15:0]);
            dpgc_pkg::REG_OFFSET:   cfg_in.plane_offset   = $signed(csr_data);
            dpgc_pkg::REG_LIMIT:    cfg_in.distance_limit = csr_data[30:0];
            dpgc_pkg::REG_BASELINE: cfg_in.baseline_len   = csr_data;
            dpgc_pkg::REG_FOCAL:    cfg_in.focal_len      = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_a        <= 16'sd0;
         cfg_ff.plane_b        <= 16'sd32767;
         cfg_ff.plane_c        <= 16'sd0;
         cfg_ff.plane_offset   <= 32'sd0;
         cfg_ff.distance_limit <= 31'd0;
         cfg_ff.baseline_len   <= 32'd65536;
         cfg_ff.focal_len      <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // global stall: everything moves when the output slot is free or being drained
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   dpgc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .column    (req_column),
      .row       (req_row),
      .disparity (req_disparity),
      .pixel_in  (req_pixel_in),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_m     (f_m),
      .out_l2    (f_l2),
      .out_nq    (f_nq),
      .out_side  (f_side)
   );

   dpgc_square u_square (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_m      (f_m),
      .in_l2     (f_l2),
      .in_nq     (f_nq),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_sq    (s_sq),
      .out_r     (s_r),
      .out_side  (s_side)
   );

   // stage 7: strict compare against the limit term scaled by 2^34
   always_comb begin
      logic less;
      less = s_sq < {dpgc_pkg::SQ_W'(s_r) << dpgc_pkg::RSH};
      rsp_valid_in = s_valid;
      gnd_in       = s_side.disp_nz && less;
      pix_in       = gnd_in ? dpgc_pkg::PIX_GROUND : s_side.pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in;
         gnd_ff <= gnd_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pix_ff;
   assign rsp_is_ground = gnd_ff;

`ifndef SYNTHESIS
   a_ground_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_ground |-> rsp_pixel_out == dpgc_pkg::PIX_GROUND)
      else $error("ground result without ground pixel value");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_ground))
      else $error("pipeline advanced during stall");
`endif

endmodule
